### src/stdp_synapse_update_unit_macros.svh
// Assertion macros shared by the STDP synapse update unit.
`ifndef STDP_SYNAPSE_UPDATE_UNIT_MACROS_SVH
`define STDP_SYNAPSE_UPDATE_UNIT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define STDPSU_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stdpsu assertion failed");

// Check that a condition implies another a fixed number of cycles later.
`define STDPSU_ASSERT_DELAY(label, ante, n, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error("stdpsu assertion failed");

`endif

### src/stdpsu_pkg.sv
// Shared constants, codes and types of the STDP synapse update unit.
package stdpsu_pkg;

    localparam int NUM_SYNAPSES = 1024;
    localparam int ADDR_W       = $clog2(NUM_SYNAPSES);

    localparam int IDX_W      = 10;
    localparam int TRACE_W    = 32;
    localparam int WEIGHT_W   = 32;
    localparam int FRAC_W     = 24;
    localparam int FACTOR_W   = 25;
    localparam int DRIFT_W    = 26;
    localparam int WMAX_W     = 31;
    localparam int PROD_W     = FACTOR_W + TRACE_W;
    localparam int SCALED_W   = PROD_W - FRAC_W;
    localparam int DW_W       = SCALED_W + 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int OUT_DEPTH = 8;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    // 1.0 in Q8.24, sized for a trace sum with two guard bits
    localparam logic [TRACE_W+1:0] ONE_FRAC =
        {{(TRACE_W + 1 - FRAC_W){1'b0}}, 1'b1, {FRAC_W{1'b0}}};

    // Request codes
    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_TICK = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PRE_DECAY       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POST_DECAY      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPRESS_GAIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POTENTIATE_GAIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIFT_STEP      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_MAX      = 3'd5;

    // Register reset values
    localparam logic [FACTOR_W-1:0] RST_PRE_DECAY       = 25'd16749277;
    localparam logic [FACTOR_W-1:0] RST_POST_DECAY      = 25'd16610280;
    localparam logic [FACTOR_W-1:0] RST_DEPRESS_GAIN    = 25'd15099494;
    localparam logic [FACTOR_W-1:0] RST_POTENTIATE_GAIN = 25'd1677722;
    localparam logic [DRIFT_W-1:0]  RST_DRIFT_STEP      = 26'd1678;
    localparam logic [WMAX_W-1:0]   RST_WEIGHT_MAX      = 31'd10905190;

    typedef struct packed {
        logic [FACTOR_W-1:0] pre_decay;
        logic [FACTOR_W-1:0] post_decay;
        logic [FACTOR_W-1:0] depress_gain;
        logic [FACTOR_W-1:0] potentiate_gain;
        logic [DRIFT_W-1:0]  drift_step;
        logic [WMAX_W-1:0]   weight_max;
    } cfg_t;

    typedef struct packed {
        logic                vld;
        logic [1:0]          kind;
        logic [IDX_W-1:0]    idx;
        logic                ok;
        logic                pre_s;
        logic                post_s;
        logic [WEIGHT_W-1:0] weight_in;
    } item_t;

    typedef struct packed {
        item_t              item;
        logic [TRACE_W-1:0] pt;
        logic [TRACE_W-1:0] qt;
    } trc_t;

    typedef struct packed {
        logic               we;
        logic [ADDR_W-1:0]  addr;
        logic [TRACE_W-1:0] pt;
        logic [TRACE_W-1:0] qt;
    } trc_wr_t;

    typedef struct packed {
        logic                re;
        logic [ADDR_W-1:0]   raddr;
        logic                we;
        logic [ADDR_W-1:0]   waddr;
        logic [WEIGHT_W-1:0] wdata;
    } wgt_ram_t;

    typedef struct packed {
        logic [WMAX_W-1:0] weight;
        logic [IDX_W-1:0]  index;
    } res_word_t;

    typedef struct packed {
        logic      vld;
        res_word_t word;
    } push_t;

endpackage

### src/stdpsu_if.sv
// Handshake channel interfaces of the STDP synapse update unit.
interface stdpsu_req_if import stdpsu_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [1:0]                 req_type;
    logic [IDX_W-1:0]           synapse_index;
    logic                       pre_spike;
    logic                       post_spike;
    logic signed [WEIGHT_W-1:0] weight_in;

    modport source (output valid, req_type, synapse_index, pre_spike, post_spike,
                    weight_in, input ready);
    modport sink (input valid, req_type, synapse_index, pre_spike, post_spike,
                  weight_in, output ready);
endinterface

interface stdpsu_res_if import stdpsu_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WMAX_W-1:0] weight_out;
    logic [IDX_W-1:0]  index_out;

    modport source (output valid, weight_out, index_out, input ready);
    modport sink (input valid, weight_out, index_out, output ready);
endinterface

interface stdpsu_cfg_if import stdpsu_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### src/stdpsu_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module stdpsu_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 1024,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] ram_mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= ram_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/stdpsu_trace_unit.sv
// Trace stage: forward, decay, spike-add and saturation of the pre and post traces.
module stdpsu_trace_unit import stdpsu_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  cfg_t                   cfg,
    input  item_t                  item_in,
    input  logic [2*TRACE_W-1:0]   rd_data,
    output trc_wr_t                wr,
    output trc_t                   trc_out
);

    item_t              p1_reg;
    logic               p1_vld_reg;
    trc_t               p2_reg;
    trc_t               p2_next;
    logic               p2_vld_reg;
    logic               p2_wr_reg;

    logic               fwd;
    logic               wrote;
    logic [TRACE_W-1:0] pre_old;
    logic [TRACE_W-1:0] post_old;
    logic [PROD_W-1:0]  pre_prod;
    logic [PROD_W-1:0]  post_prod;
    logic [TRACE_W+1:0] pre_sum;
    logic [TRACE_W+1:0] post_sum;
    logic [TRACE_W-1:0] pre_new;
    logic [TRACE_W-1:0] post_new;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            p2_wr_reg  <= 1'b0;
        end
        else
        begin
            p1_vld_reg <= item_in.vld;
            p2_vld_reg <= p1_vld_reg;
            p2_wr_reg  <= wrote;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_reg <= item_in;
        p2_reg <= p2_next;
    end

    // Take the last written traces when the RAM read raced that write
    assign fwd      = p2_wr_reg && (p2_reg.item.idx == p1_reg.idx);
    assign pre_old  = fwd ? p2_reg.pt : rd_data[2*TRACE_W-1:TRACE_W];
    assign post_old = fwd ? p2_reg.qt : rd_data[TRACE_W-1:0];

    assign pre_prod  = PROD_W'(cfg.pre_decay) * PROD_W'(pre_old);
    assign post_prod = PROD_W'(cfg.post_decay) * PROD_W'(post_old);
    assign pre_sum   = (TRACE_W + 2)'(pre_prod[PROD_W-1:FRAC_W])
                     + (p1_reg.pre_s ? ONE_FRAC : '0);
    assign post_sum  = (TRACE_W + 2)'(post_prod[PROD_W-1:FRAC_W])
                     + (p1_reg.post_s ? ONE_FRAC : '0);
    assign pre_new   = (|pre_sum[TRACE_W+1:TRACE_W]) ? '1 : pre_sum[TRACE_W-1:0];
    assign post_new  = (|post_sum[TRACE_W+1:TRACE_W]) ? '1 : post_sum[TRACE_W-1:0];

    assign wrote = p1_vld_reg && p1_reg.ok && (p1_reg.kind == REQ_TICK);

    always_comb
    begin
        wr.we   = wrote;
        wr.addr = ADDR_W'(p1_reg.idx);
        wr.pt   = pre_new;
        wr.qt   = post_new;

        p2_next.item     = p1_reg;
        p2_next.item.vld = p1_vld_reg;
        p2_next.pt       = pre_new;
        p2_next.qt       = post_new;

        trc_out          = p2_reg;
        trc_out.item.vld = p2_vld_reg;
    end

endmodule

### src/stdpsu_weight_unit.sv
// Weight stages: gain products, weight delta, saturating update and read clamp.
module stdpsu_weight_unit import stdpsu_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  trc_t                trc_in,
    input  logic [WEIGHT_W-1:0] rd_data,
    output wgt_ram_t            ram,
    output push_t               push
);

    localparam logic [WEIGHT_W-1:0] W_POS_MAX = {1'b0, {(WEIGHT_W - 1){1'b1}}};
    localparam logic [WEIGHT_W-1:0] W_NEG_MIN = {1'b1, {(WEIGHT_W - 1){1'b0}}};

    item_t               q3_item_reg;
    logic                q3_vld_reg;
    logic [SCALED_W-1:0] q3_dep_reg;
    logic [SCALED_W-1:0] q3_pot_reg;
    item_t               q4_item_reg;
    logic                q4_vld_reg;
    logic [DW_W-1:0]     q4_dw_reg;
    logic [DW_W-1:0]     q4_dw_next;
    logic                wb_vld_reg;
    logic [IDX_W-1:0]    wb_idx_reg;
    logic [WEIGHT_W-1:0] wb_data_reg;

    logic [PROD_W-1:0]   dep_prod;
    logic [PROD_W-1:0]   pot_prod;
    logic                fwd;
    logic [WEIGHT_W-1:0] w_old;
    logic [DW_W:0]       w_sum;
    logic [DW_W-WEIGHT_W+1:0] w_hi;
    logic [WEIGHT_W-1:0] w_new;
    logic                w_we;
    logic [WMAX_W-1:0]   w_clamp;

    assign dep_prod = PROD_W'(cfg.depress_gain) * PROD_W'(trc_in.pt);
    assign pot_prod = PROD_W'(cfg.potentiate_gain) * PROD_W'(trc_in.qt);

    // Sign-extended drift, minus depression on a post spike, plus potentiation on a pre spike
    always_comb
    begin
        q4_dw_next = {{(DW_W - DRIFT_W){cfg.drift_step[DRIFT_W-1]}}, cfg.drift_step};
        if (q3_item_reg.post_s)
        begin
            q4_dw_next = q4_dw_next - DW_W'(q3_dep_reg);
        end
        if (q3_item_reg.pre_s)
        begin
            q4_dw_next = q4_dw_next + DW_W'(q3_pot_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q3_vld_reg <= 1'b0;
            q4_vld_reg <= 1'b0;
            wb_vld_reg <= 1'b0;
        end
        else
        begin
            q3_vld_reg <= trc_in.item.vld;
            q4_vld_reg <= q3_vld_reg;
            wb_vld_reg <= w_we;
        end
    end

    always_ff @(posedge clk)
    begin
        q3_item_reg <= trc_in.item;
        q3_dep_reg  <= dep_prod[PROD_W-1:FRAC_W];
        q3_pot_reg  <= pot_prod[PROD_W-1:FRAC_W];
        q4_item_reg <= q3_item_reg;
        q4_dw_reg   <= q4_dw_next;
        wb_idx_reg  <= q4_item_reg.idx;
        wb_data_reg <= ram.wdata;
    end

    // Take the last written weight when the RAM read raced that write
    assign fwd   = wb_vld_reg && (wb_idx_reg == q4_item_reg.idx);
    assign w_old = fwd ? wb_data_reg : rd_data;

    assign w_sum = {{(DW_W + 1 - WEIGHT_W){w_old[WEIGHT_W-1]}}, w_old}
                 + {q4_dw_reg[DW_W-1], q4_dw_reg};
    assign w_hi  = w_sum[DW_W:WEIGHT_W-1];

    always_comb
    begin
        if ((w_hi == '0) || (w_hi == '1))
        begin
            w_new = w_sum[WEIGHT_W-1:0];
        end
        else if (w_sum[DW_W])
        begin
            w_new = W_NEG_MIN;
        end
        else
        begin
            w_new = W_POS_MAX;
        end
    end

    always_comb
    begin
        if (!q4_item_reg.ok || w_old[WEIGHT_W-1])
        begin
            w_clamp = '0;
        end
        else if (w_old[WMAX_W-1:0] > cfg.weight_max)
        begin
            w_clamp = cfg.weight_max;
        end
        else
        begin
            w_clamp = w_old[WMAX_W-1:0];
        end
    end

    assign w_we = q4_vld_reg && q4_item_reg.ok
               && ((q4_item_reg.kind == REQ_LOAD) || (q4_item_reg.kind == REQ_TICK));

    always_comb
    begin
        ram.re    = q3_vld_reg;
        ram.raddr = ADDR_W'(q3_item_reg.idx);
        ram.we    = w_we;
        ram.waddr = ADDR_W'(q4_item_reg.idx);
        ram.wdata = (q4_item_reg.kind == REQ_LOAD) ? q4_item_reg.weight_in : w_new;

        push.vld         = q4_vld_reg && (q4_item_reg.kind == REQ_READ);
        push.word.weight = w_clamp;
        push.word.index  = q4_item_reg.idx;
    end

endmodule

### src/stdpsu_out_fifo.sv
// Result buffer between the weight stage and the result channel.
module stdpsu_out_fifo import stdpsu_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  push_t         push,
    stdpsu_res_if.source  res
);

    res_word_t            fifo_mem [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] wr_ptr_reg;
    logic [OUT_PTR_W-1:0] rd_ptr_reg;
    logic [OUT_CNT_W-1:0] cnt_reg;
    logic [OUT_CNT_W-1:0] cnt_next;
    logic                 pop;
    res_word_t            head;

    assign pop = res.valid && res.ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push.vld && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!push.vld && pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push.vld)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.vld)
        begin
            fifo_mem[wr_ptr_reg] <= push.word;
        end
    end

    assign head           = fifo_mem[rd_ptr_reg];
    assign res.valid      = (cnt_reg != '0);
    assign res.weight_out = head.weight;
    assign res.index_out  = head.index;

endmodule

### src/stdp_synapse_update_unit.sv
// Top level of the STDP synapse update unit.
//
// Channels: req takes load, tick and read words; res returns one word per read
// (clamped weight and index); cfg writes the six learning registers, always ready.
// Throughput: one request word per cycle while req is ready, also back to back on
// the same synapse. A read passes the p1, p2, q3 and q4 registers and the result
// buffer on its way to res. The trace loop (decay multiply, spike add, saturate)
// is combinational on the trace RAM read port, the weight loop (add, saturate) on
// the weight RAM; a writeback register per RAM bypasses a same-synapse write.
// Reset: the trace RAM is cleared by a sweep over all NUM_SYNAPSES entries, one
// entry per cycle, during which req is not ready; cfg writes are taken throughout.
// Weights are not cleared: load a synapse before a tick or read addresses it.
// Receiver stall: up to OUT_DEPTH (8) read results are buffered; req drops ready
// once that many reads are accepted and not yet taken.
`include "stdp_synapse_update_unit_macros.svh"

module stdp_synapse_update_unit import stdpsu_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    stdpsu_cfg_if.sink   cfg,
    stdpsu_req_if.sink   req,
    stdpsu_res_if.source res
);

    cfg_t                 cfg_reg;
    logic                 clr_busy_reg;
    logic [ADDR_W-1:0]    clr_addr_reg;
    logic [OUT_CNT_W-1:0] pend_reg;
    logic [OUT_CNT_W-1:0] pend_next;

    logic                 req_acc;
    logic                 req_is_read;
    logic                 res_pop;
    item_t                item_in;
    logic [2*TRACE_W-1:0] trc_rd_data;
    trc_wr_t              trc_wr;
    trc_t                 trc_mid;
    logic                 trc_we;
    logic [ADDR_W-1:0]    trc_waddr;
    logic [2*TRACE_W-1:0] trc_wdata;
    logic [WEIGHT_W-1:0]  wgt_rd_data;
    wgt_ram_t             wgt_ram;
    push_t                push;

    // Configuration registers: always ready, drop writes beyond the list
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pre_decay       <= RST_PRE_DECAY;
            cfg_reg.post_decay      <= RST_POST_DECAY;
            cfg_reg.depress_gain    <= RST_DEPRESS_GAIN;
            cfg_reg.potentiate_gain <= RST_POTENTIATE_GAIN;
            cfg_reg.drift_step      <= RST_DRIFT_STEP;
            cfg_reg.weight_max      <= RST_WEIGHT_MAX;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_PRE_DECAY:       cfg_reg.pre_decay       <= cfg.data[FACTOR_W-1:0];
                CFG_POST_DECAY:      cfg_reg.post_decay      <= cfg.data[FACTOR_W-1:0];
                CFG_DEPRESS_GAIN:    cfg_reg.depress_gain    <= cfg.data[FACTOR_W-1:0];
                CFG_POTENTIATE_GAIN: cfg_reg.potentiate_gain <= cfg.data[FACTOR_W-1:0];
                CFG_DRIFT_STEP:      cfg_reg.drift_step      <= cfg.data[DRIFT_W-1:0];
                CFG_WEIGHT_MAX:      cfg_reg.weight_max      <= cfg.data[WMAX_W-1:0];
                default:             ;
            endcase
        end
    end

    // Clear sweep over the trace RAM after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            if (clr_addr_reg == ADDR_W'(NUM_SYNAPSES - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
            else
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    // Credit for result words: count accepted reads not yet taken on res
    assign req_is_read = (req.req_type == REQ_READ);
    assign req.ready   = !clr_busy_reg && (pend_reg < OUT_CNT_W'(OUT_DEPTH));
    assign req_acc     = req.valid && req.ready;
    assign res_pop     = res.valid && res.ready;

    always_comb
    begin
        pend_next = pend_reg;
        if ((req_acc && req_is_read) && !res_pop)
        begin
            pend_next = pend_reg + 1'b1;
        end
        else if (!(req_acc && req_is_read) && res_pop)
        begin
            pend_next = pend_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // Request word into the pipeline; out-of-range synapses are flagged, not dropped
    always_comb
    begin
        item_in.vld       = req_acc;
        item_in.kind      = req.req_type;
        item_in.idx       = req.synapse_index;
        item_in.ok        = (32'(req.synapse_index) < 32'(NUM_SYNAPSES));
        item_in.pre_s     = req.pre_spike;
        item_in.post_s    = req.post_spike;
        item_in.weight_in = req.weight_in;
    end

    // Trace RAM write: the clear sweep owns the port until it is done
    assign trc_we    = clr_busy_reg || trc_wr.we;
    assign trc_waddr = clr_busy_reg ? clr_addr_reg : trc_wr.addr;
    assign trc_wdata = clr_busy_reg ? '0 : {trc_wr.pt, trc_wr.qt};

    stdpsu_ram #(
        .WIDTH (2 * TRACE_W),
        .DEPTH (NUM_SYNAPSES)
    ) u_trace_ram (
        .clk   (clk),
        .we    (trc_we),
        .waddr (trc_waddr),
        .wdata (trc_wdata),
        .re    (req_acc),
        .raddr (ADDR_W'(req.synapse_index)),
        .rdata (trc_rd_data)
    );

    stdpsu_trace_unit u_trace (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .item_in (item_in),
        .rd_data (trc_rd_data),
        .wr      (trc_wr),
        .trc_out (trc_mid)
    );

    stdpsu_ram #(
        .WIDTH (WEIGHT_W),
        .DEPTH (NUM_SYNAPSES)
    ) u_weight_ram (
        .clk   (clk),
        .we    (wgt_ram.we),
        .waddr (wgt_ram.waddr),
        .wdata (wgt_ram.wdata),
        .re    (wgt_ram.re),
        .raddr (wgt_ram.raddr),
        .rdata (wgt_rd_data)
    );

    stdpsu_weight_unit u_weight (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .trc_in  (trc_mid),
        .rd_data (wgt_rd_data),
        .ram     (wgt_ram),
        .push    (push)
    );

    stdpsu_out_fifo u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .res   (res)
    );

    // Hold off requests while the trace RAM is being cleared
    `STDPSU_ASSERT_IMPL(a_clear_blocks_req, clr_busy_reg, !req.ready)
    // Never owe more result words than the buffer holds
    `STDPSU_ASSERT_IMPL(a_credit_bound, 1'b1, pend_reg <= OUT_CNT_W'(OUT_DEPTH))
    // A read pushes its result word once it reaches the q4 register, after p1, p2 and q3
    `STDPSU_ASSERT_DELAY(a_read_latency, req_acc && req_is_read, 4, push.vld)

endmodule

### verif/stdp_synapse_update_unit_tb.sv
// Self-checking testbench for the STDP synapse update unit: random and directed traffic.
`timescale 1ns / 1ps

module stdp_synapse_update_unit_tb;
    import stdpsu_pkg::*;

    // req_type 3 has no meaning; the block must drop it without a result
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_WORDS   = 225;

    // One request word as the sender sees it
    typedef struct packed {
        logic [1:0]          kind;
        logic [IDX_W-1:0]    idx;
        logic                pre_s;
        logic                post_s;
        logic [WEIGHT_W-1:0] weight_in;
    } req_word_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    stdpsu_req_if req_bus ();
    stdpsu_res_if res_bus ();
    stdpsu_cfg_if cfg_bus ();

    stdp_synapse_update_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_bus),
        .req   (req_bus),
        .res   (res_bus)
    );

    // 12 ns period, high then low
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the synapse table and the learning registers
    // ------------------------------------------------------------------
    logic [TRACE_W-1:0]         pre_trace_mem  [NUM_SYNAPSES];
    logic [TRACE_W-1:0]         post_trace_mem [NUM_SYNAPSES];
    logic signed [WEIGHT_W-1:0] weight_mem     [NUM_SYNAPSES];
    cfg_t                       learn_cfg;

    // Clamped weights the block still owes, oldest first
    res_word_t read_results_due [$];

    // Words waiting for the driver, and the one currently on the bus
    req_word_t words_waiting [$];
    req_word_t word_on_bus;

    // Stimulus bookkeeping: which synapses hold a loaded weight
    bit               synapse_loaded [NUM_SYNAPSES];
    logic [IDX_W-1:0] loaded_list [$];
    logic [IDX_W-1:0] synapse_pool [$];

    int words_queued     = 0;
    int words_accepted   = 0;
    int reads_checked    = 0;
    int mismatch_count   = 0;
    int settings_written = 0;
    int cycle_count      = 0;
    int sender_gap_pct   = 0;
    int sink_stall_pct   = 0;

    // Full factor-times-trace product, scaled back by the fraction width.
    // Both operands are non-negative, so the shift truncates toward zero.
    function automatic logic [63:0] scaled_product(logic [FACTOR_W-1:0] factor,
                                                   logic [TRACE_W-1:0] trace);
        return ({{(64 - FACTOR_W){1'b0}}, factor} * {32'd0, trace}) >> FRAC_W;
    endfunction

    // Decay a trace, add 1.0 on a spike, and saturate at the 32-bit range
    function automatic logic [TRACE_W-1:0] decayed_trace(logic [TRACE_W-1:0] trace,
                                                         logic [FACTOR_W-1:0] factor,
                                                         logic spike);
        logic [63:0] sum;
        sum = scaled_product(factor, trace);
        if (spike)
            sum = sum + (64'd1 << FRAC_W);
        if (sum > 64'hFFFF_FFFF)
            sum = 64'hFFFF_FFFF;
        return sum[TRACE_W-1:0];
    endfunction

    // Advance the shadow table by one accepted word; queue the result a read owes
    function automatic void step_synapse_table(req_word_t w);
        logic [TRACE_W-1:0] pt;
        logic [TRACE_W-1:0] qt;
        longint             delta;
        longint             wsum;
        res_word_t          rd;
        case (w.kind)
            REQ_LOAD:
            begin
                if (w.idx < NUM_SYNAPSES)
                    weight_mem[w.idx] = w.weight_in;
            end
            REQ_TICK:
            begin
                if (w.idx < NUM_SYNAPSES)
                begin
                    pt = decayed_trace(pre_trace_mem[w.idx], learn_cfg.pre_decay, w.pre_s);
                    qt = decayed_trace(post_trace_mem[w.idx], learn_cfg.post_decay, w.post_s);
                    pre_trace_mem[w.idx]  = pt;
                    post_trace_mem[w.idx] = qt;
                    // Weight change uses the traces just updated
                    delta = longint'(signed'(learn_cfg.drift_step));
                    if (w.post_s)
                        delta = delta - longint'(scaled_product(learn_cfg.depress_gain, pt));
                    if (w.pre_s)
                        delta = delta + longint'(scaled_product(learn_cfg.potentiate_gain, qt));
                    wsum = longint'(weight_mem[w.idx]) + delta;
                    if (wsum > 64'sd2147483647)
                        wsum = 64'sd2147483647;
                    if (wsum < -64'sd2147483648)
                        wsum = -64'sd2147483648;
                    weight_mem[w.idx] = wsum[WEIGHT_W-1:0];
                end
            end
            REQ_READ:
            begin
                rd.index  = w.idx;
                rd.weight = '0;
                if (w.idx < NUM_SYNAPSES)
                begin
                    wsum = longint'(weight_mem[w.idx]);
                    if (wsum > longint'(learn_cfg.weight_max))
                        rd.weight = learn_cfg.weight_max;
                    else if (wsum > 0)
                        rd.weight = wsum[WMAX_W-1:0];
                end
                read_results_due.push_back(rd);
            end
            default:
            begin
            end
        endcase
    endfunction

    // Print one line per mismatch and count it
    task automatic flag_mismatch(string msg);
        mismatch_count++;
        $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------
    // Request driver: present the next waiting word once the current one is
    // taken, with random gaps set by sender_gap_pct
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : drive_requests
        logic take_next;
        if (!rst_n)
        begin
            req_bus.valid <= 1'b0;
        end
        else
        begin
            take_next = !req_bus.valid;
            if (req_bus.valid && req_bus.ready)
            begin
                step_synapse_table(word_on_bus);
                words_accepted++;
                take_next = 1'b1;
            end
            if (take_next)
            begin
                if (words_waiting.size() != 0 && $urandom_range(99) >= sender_gap_pct)
                begin
                    word_on_bus = words_waiting.pop_front();
                    req_bus.valid         <= 1'b1;
                    req_bus.req_type      <= word_on_bus.kind;
                    req_bus.synapse_index <= word_on_bus.idx;
                    req_bus.pre_spike     <= word_on_bus.pre_s;
                    req_bus.post_spike    <= word_on_bus.post_s;
                    req_bus.weight_in     <= word_on_bus.weight_in;
                end
                else
                begin
                    // Idle: scramble the payload so nothing leaks through without valid
                    req_bus.valid         <= 1'b0;
                    req_bus.req_type      <= 2'($urandom);
                    req_bus.synapse_index <= IDX_W'($urandom);
                    req_bus.pre_spike     <= 1'($urandom);
                    req_bus.post_spike    <= 1'($urandom);
                    req_bus.weight_in     <= $urandom;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: compare each taken word with the oldest due read,
    // then pick the next ready at random per sink_stall_pct
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        res_word_t due;
        if (!rst_n)
        begin
            res_bus.ready <= 1'b0;
        end
        else
        begin
            if (res_bus.valid && res_bus.ready)
            begin
                if (read_results_due.size() == 0)
                begin
                    flag_mismatch($sformatf("result with no read due: index %0d weight 0x%08h",
                                            res_bus.index_out, res_bus.weight_out));
                end
                else
                begin
                    due = read_results_due.pop_front();
                    reads_checked++;
                    if (res_bus.weight_out !== due.weight)
                        flag_mismatch($sformatf("index %0d: weight_out 0x%08h, want 0x%08h",
                                                due.index, res_bus.weight_out, due.weight));
                    if (res_bus.index_out !== due.index)
                        flag_mismatch($sformatf("index_out %0d, want %0d",
                                                res_bus.index_out, due.index));
                end
            end
            res_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Watchdog: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d reads still due",
                     cycle_count, read_results_due.size());
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Hand one word to the driver; remember which synapses now hold a weight
    task automatic queue_word(logic [1:0] kind, logic [IDX_W-1:0] idx, logic pre_s,
                              logic post_s, logic [WEIGHT_W-1:0] weight_in);
        req_word_t w;
        w.kind      = kind;
        w.idx       = idx;
        w.pre_s     = pre_s;
        w.post_s    = post_s;
        w.weight_in = weight_in;
        words_waiting.push_back(w);
        words_queued++;
        if (kind == REQ_LOAD && !synapse_loaded[idx])
        begin
            synapse_loaded[idx] = 1'b1;
            loaded_list.push_back(idx);
        end
    endtask

    // Favor the small pool so traces build up; fall back to any loaded synapse
    function automatic logic [IDX_W-1:0] pick_loaded();
        logic [IDX_W-1:0] idx;
        idx = synapse_pool[$urandom_range(synapse_pool.size() - 1)];
        if (!synapse_loaded[idx] || $urandom_range(3) == 0)
            idx = loaded_list[$urandom_range(loaded_list.size() - 1)];
        return idx;
    endfunction

    // Mostly well-formed bursts (optional load, a run of ticks, read) on one synapse,
    // the rest single stray words; unused request codes do not count
    task automatic queue_random_words(int count);
        int               made;
        int               ticks;
        logic [IDX_W-1:0] idx;
        logic [31:0]      wv;
        made = 0;
        while (made < count)
        begin
            if (loaded_list.size() == 0 || $urandom_range(99) < 80)
            begin
                if (loaded_list.size() == 0 || $urandom_range(99) < 35)
                begin
                    if ($urandom_range(99) < 70)
                        idx = synapse_pool[$urandom_range(synapse_pool.size() - 1)];
                    else
                        idx = IDX_W'($urandom_range(NUM_SYNAPSES - 1));
                    case ($urandom_range(3))
                        0: wv = $urandom;
                        1: wv = $urandom_range(32'h01FF_FFFF) - 32'h00FF_FFFF;
                        2: wv = $urandom_range(32'h0100_0000);
                        default: wv = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                    endcase
                    queue_word(REQ_LOAD, idx, 1'($urandom), 1'($urandom), wv);
                    made++;
                end
                else
                begin
                    idx = pick_loaded();
                end
                ticks = $urandom_range(1, 8);
                repeat (ticks)
                    queue_word(REQ_TICK, idx, 1'($urandom), 1'($urandom), $urandom);
                queue_word(REQ_READ, idx, 1'($urandom), 1'($urandom), $urandom);
                made += ticks + 1;
            end
            else
            begin
                case ($urandom_range(3))
                    0: queue_word(REQ_UNUSED, IDX_W'($urandom), 1'($urandom), 1'($urandom),
                                  $urandom);
                    1:
                    begin
                        queue_word(REQ_TICK, pick_loaded(), 1'($urandom), 1'($urandom),
                                   $urandom);
                        made++;
                    end
                    default:
                    begin
                        queue_word(REQ_READ, pick_loaded(), 1'($urandom), 1'($urandom),
                                   $urandom);
                        made++;
                    end
                endcase
            end
        end
    endtask

    // Block until every queued word is taken and every read answered, then
    // idle for the settle period so ticks still in the pipeline retire
    task automatic wait_for_quiet(int settle);
        while (words_accepted != words_queued || read_results_due.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // One register write; the shadow copy takes the value with upper bits dropped
    task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= index;
        cfg_bus.data  <= data;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        case (index)
            CFG_PRE_DECAY:       learn_cfg.pre_decay       = data[FACTOR_W-1:0];
            CFG_POST_DECAY:      learn_cfg.post_decay      = data[FACTOR_W-1:0];
            CFG_DEPRESS_GAIN:    learn_cfg.depress_gain    = data[FACTOR_W-1:0];
            CFG_POTENTIATE_GAIN: learn_cfg.potentiate_gain = data[FACTOR_W-1:0];
            CFG_DRIFT_STEP:      learn_cfg.drift_step      = data[DRIFT_W-1:0];
            CFG_WEIGHT_MAX:      learn_cfg.weight_max      = data[WMAX_W-1:0];
            default:
            begin
            end
        endcase
    endtask

    // Write all six learning registers back to back, then drop valid
    task automatic program_registers(logic [31:0] pre_decay, logic [31:0] post_decay,
                                     logic [31:0] depress, logic [31:0] potentiate,
                                     logic [31:0] drift, logic [31:0] weight_max);
        write_register(CFG_PRE_DECAY, pre_decay);
        write_register(CFG_POST_DECAY, post_decay);
        write_register(CFG_DEPRESS_GAIN, depress);
        write_register(CFG_POTENTIATE_GAIN, potentiate);
        write_register(CFG_DRIFT_STEP, drift);
        write_register(CFG_WEIGHT_MAX, weight_max);
        cfg_bus.valid <= 1'b0;
        settings_written++;
    endtask

    // ------------------------------------------------------------------
    // Run sequence
    // ------------------------------------------------------------------
    initial
    begin
        int k;
        int phase;

        // Drive every block input to a known value before the first edge
        req_bus.valid         = 1'b0;
        req_bus.req_type      = REQ_LOAD;
        req_bus.synapse_index = '0;
        req_bus.pre_spike     = 1'b0;
        req_bus.post_spike    = 1'b0;
        req_bus.weight_in     = '0;
        res_bus.ready         = 1'b0;
        cfg_bus.valid         = 1'b0;
        cfg_bus.index         = CFG_PRE_DECAY;
        cfg_bus.data          = '0;

        // Shadow state after reset: traces clear, registers at their defaults
        for (k = 0; k < NUM_SYNAPSES; k++)
        begin
            pre_trace_mem[k]  = '0;
            post_trace_mem[k] = '0;
            weight_mem[k]     = '0;
        end
        learn_cfg.pre_decay       = RST_PRE_DECAY;
        learn_cfg.post_decay      = RST_POST_DECAY;
        learn_cfg.depress_gain    = RST_DEPRESS_GAIN;
        learn_cfg.potentiate_gain = RST_POTENTIATE_GAIN;
        learn_cfg.drift_step      = RST_DRIFT_STEP;
        learn_cfg.weight_max      = RST_WEIGHT_MAX;

        // Small pool of synapses that bursts keep returning to; the corner
        // indexes flip every address bit both ways
        synapse_pool.push_back(10'd0);
        synapse_pool.push_back(10'd1023);
        synapse_pool.push_back(10'h155);
        synapse_pool.push_back(10'h2AA);
        repeat (12) synapse_pool.push_back(IDX_W'($urandom_range(NUM_SYNAPSES - 1)));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words under the reset register values. The driver holds
        // them until the trace clear sweep lets req go ready.
        // Largest weight: read clamps to weight_max, positive drift saturates.
        queue_word(REQ_LOAD, 10'd0, 1'b1, 1'b1, 32'h7FFF_FFFF);
        queue_word(REQ_READ, 10'd0, 1'b0, 1'b0, 32'hFFFF_FFFF);
        queue_word(REQ_TICK, 10'd0, 1'b0, 1'b0, 32'h0000_0000);
        queue_word(REQ_READ, 10'd0, 1'b1, 1'b1, 32'h5555_5555);
        // Most negative weight: read clamps to zero; the post-spike tick meets a clear pre trace, so no depression
        queue_word(REQ_LOAD, 10'd1023, 1'b0, 1'b0, 32'h8000_0000);
        queue_word(REQ_READ, 10'd1023, 1'b0, 1'b0, 32'hAAAA_AAAA);
        queue_word(REQ_TICK, 10'd1023, 1'b0, 1'b1, 32'hFFFF_FFFF);
        queue_word(REQ_READ, 10'd1023, 1'b0, 1'b0, 32'h0000_0000);
        // Mid-range weight through ticks with both spikes, pre only and post only
        queue_word(REQ_LOAD, 10'h155, 1'b0, 1'b0, 32'h0080_0000);
        queue_word(REQ_TICK, 10'h155, 1'b1, 1'b1, 32'h0000_0000);
        queue_word(REQ_TICK, 10'h155, 1'b1, 1'b0, 32'h0000_0000);
        queue_word(REQ_TICK, 10'h155, 1'b0, 1'b1, 32'h0000_0000);
        queue_word(REQ_READ, 10'h155, 1'b0, 1'b0, 32'h0000_0000);
        // Unused request code: must vanish without a result
        queue_word(REQ_UNUSED, 10'h2AA, 1'b1, 1'b1, 32'hFFFF_FFFF);
        wait_for_quiet(SETTLE_CYCLES);

        // Decays near 2.0 (upper data bits set and dropped) so a run of pre spikes
        // drives the pre trace into saturation and the post trace up; the weight follows
        program_registers(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          32'h01FF_FFFF, 32'h7FFF_FFFF);
        queue_word(REQ_LOAD, 10'h2AA, 1'b0, 1'b0, 32'h0000_0000);
        for (k = 0; k < 9; k++)
            queue_word(REQ_TICK, 10'h2AA, 1'b1, (k % 3 == 2), $urandom);
        queue_word(REQ_READ, 10'h2AA, 1'b0, 1'b0, 32'h0000_0000);

        // Random phases: each sets the learning registers and an idling pattern first
        for (phase = 0; phase < 6; phase++)
        begin
            wait_for_quiet(SETTLE_CYCLES);
            case (phase)
                0:
                begin
                    program_registers(32'(RST_PRE_DECAY), 32'(RST_POST_DECAY),
                                      32'(RST_DEPRESS_GAIN), 32'(RST_POTENTIATE_GAIN),
                                      32'(RST_DRIFT_STEP), 32'(RST_WEIGHT_MAX));
                    sender_gap_pct = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    // All zero, most negative drift, read-out clamp at zero
                    program_registers(32'd0, 32'd0, 32'd0, 32'd0, 32'hFE00_0000, 32'd0);
                    sender_gap_pct = 86;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    // Plausible learning rates around the defaults
                    program_registers($urandom_range(32'h00F0_0000, 32'h0100_0000),
                                      $urandom_range(32'h00E0_0000, 32'h0100_0000),
                                      $urandom_range(32'h0100_0000),
                                      $urandom_range(32'h0100_0000),
                                      $urandom_range(32'h0020_0000) - 32'h0010_0000,
                                      $urandom_range(32'h0400_0000));
                    sender_gap_pct = 0;
                    sink_stall_pct = 86;
                end
                4:
                begin
                    // Pre decay exactly 1.0, everything else at its ceiling
                    program_registers(32'h0100_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                      32'hFFFF_FFFF, 32'h01FF_FFFF, 32'hFFFF_FFFF);
                    sender_gap_pct = 86;
                    sink_stall_pct = 0;
                end
                default:
                begin
                    // Raw random data, upper bits included
                    program_registers($urandom, $urandom, $urandom, $urandom,
                                      $urandom, $urandom);
                    sender_gap_pct = 10;
                    sink_stall_pct = 10;
                end
            endcase

            if (phase == 2)
            begin
                // Starve the block halfway through until every read has returned
                queue_random_words(PHASE_WORDS / 2);
                wait_for_quiet(0);
                queue_random_words(PHASE_WORDS - PHASE_WORDS / 2);
            end
            else
            begin
                queue_random_words(PHASE_WORDS);
            end
        end

        // Drain, then leave room for a stray result to show up
        wait_for_quiet(SETTLE_CYCLES);

        $display("Run: %0d request words sent, %0d read results checked, %0d mismatches",
                 words_accepted, reads_checked, mismatch_count);
        $display("Run: %0d register settings, %0d synapses loaded, %0d cycles",
                 settings_written + 1, loaded_list.size(), cycle_count);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### sim.f
+incdir+src
src/stdpsu_pkg.sv
src/stdpsu_if.sv
src/stdpsu_ram.sv
src/stdpsu_trace_unit.sv
src/stdpsu_weight_unit.sv
src/stdpsu_out_fifo.sv
src/stdp_synapse_update_unit.sv
verif/stdp_synapse_update_unit_tb.sv
